[hw/rtl/cil_pkg.sv]
// Shared types and constants of the curve interpolation lookup.
package cil_pkg;

  // Default table depth
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Field widths
  localparam int unsigned TENOR_W = 24;  // Q8.16
  localparam int unsigned VALUE_W = 32;  // Q2.30
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned QUOT_W  = 16;  // interpolation weight bits
  localparam int unsigned STEP_W  = $clog2(QUOT_W);
  // signed (v2 - v1) times unsigned weight, plus headroom for the sum
  localparam int unsigned PROD_W  = VALUE_W + 1 + QUOT_W + 1;

  // Item kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // One curve point as held in the table memory
  typedef struct packed {
    logic [TENOR_W-1:0] tenor;
    logic [VALUE_W-1:0] value;
  } point_t;

  // Query sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for a transaction
    ST_SRD,    // issue a search read
    ST_SCMP,   // compare the search read
    ST_POS,    // search done, pick the entry to fetch
    ST_EDGE,   // flat extrapolation value arrives
    ST_HI,     // upper neighbour arrives
    ST_LO,     // lower neighbour arrives
    ST_DIV,    // weight division, one bit a cycle
    ST_MUL,    // weight times value difference
    ST_SUM,    // add base value and scale down
    ST_OUT     // hand the result to the output register
  } state_e;

endpackage

[hw/rtl/cil_point_mem.sv]
// Curve point table: one write port, one read port with registered data.
module cil_point_mem #(
  parameter int unsigned DEPTH = cil_pkg::MAX_POINTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  cil_pkg::point_t  wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output cil_pkg::point_t  rd_data_o
);

  cil_pkg::point_t mem_q [DEPTH];
  cil_pkg::point_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/curve_interpolation_lookup.sv]
// Curve lookup: first-not-below search over a point table, linear interpolation, flat ends.
//
// A write transaction stores one point (tenor Q8.16, value Q2.30) and gives no result;
// slots at or above MAX_POINTS are dropped. A query runs a binary search for the first
// point whose tenor is not below the query, over the first point_count entries (capped
// at MAX_POINTS), with S <= floor(log2(n)) + 1 steps, each of which waits on the single
// table read port. Against flat extrapolation and exact matches, an interpolated point
// adds one more table read, a radix-2 divider for the 16-bit weight and a multiply and a
// sum state. An empty table answers with zero and the error flag. One query is in flight
// at a time; the input is free again in the cycle after the result is loaded, and the
// next item is taken while a finished result waits in the output register. The table holds
// no reset value: query only a curve whose first point_count entries have been written.
module curve_interpolation_lookup #(
  parameter int unsigned MAX_POINTS = cil_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [cil_pkg::COUNT_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [cil_pkg::INDEX_W-1:0]  point_index_i,
  input  logic [cil_pkg::TENOR_W-1:0]  tenor_i,
  input  logic [cil_pkg::VALUE_W-1:0]  point_value_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cil_pkg::VALUE_W-1:0]  curve_value_o,
  output logic                         empty_error_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned NW = (CW > cil_pkg::COUNT_W) ? CW : cil_pkg::COUNT_W;
  localparam int unsigned TW = cil_pkg::TENOR_W;
  localparam int unsigned VW = cil_pkg::VALUE_W;
  localparam int unsigned QW = cil_pkg::QUOT_W;
  localparam int unsigned PW = cil_pkg::PROD_W;

  // Control state
  cil_pkg::state_e state_q, state_d;
  logic [cil_pkg::COUNT_W-1:0] count_q, count_d;
  logic out_valid_q, out_valid_d;

  // Query payload
  logic [TW-1:0] tq_q, tq_d;          // queried tenor
  logic [CW-1:0] n_q, n_d;            // effective point count
  logic [CW-1:0] first_q, first_d;    // first slot not below the query
  logic [CW-1:0] cnt_q, cnt_d;        // remaining search span
  logic [TW-1:0] t2_q, t2_d;
  logic [VW-1:0] v1_q, v1_d;
  logic [VW:0]   diff_q, diff_d;      // v2 - v1, two's complement
  logic [TW-1:0] rem_q, rem_d;
  logic [TW-1:0] dvs_q, dvs_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [cil_pkg::STEP_W-1:0] step_q, step_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [VW-1:0] res_value_q, res_value_d;
  logic          res_err_q, res_err_d;
  logic [VW-1:0] out_value_q, out_value_d;
  logic          out_err_q, out_err_d;

  // Combinational helpers
  logic            in_acc;
  logic            out_load;
  logic [NW-1:0]   n_wide;
  logic [CW-1:0]   n_cap;
  logic [CW-1:0]   half;
  logic [CW-1:0]   probe;
  logic [TW:0]     rem_sh;
  logic            div_ge;
  logic [TW:0]     rem_sub;
  logic signed [PW-1:0] sum;

  // Memory ports
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  cil_pkg::point_t wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  cil_pkg::point_t rd_data;

  cil_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != cil_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == cil_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  // Count capped at the table depth
  assign n_wide = (NW'(count_q) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_q);
  assign n_cap  = CW'(n_wide);

  // Search probe and divider step
  assign half    = cnt_q >> 1;
  assign probe   = first_q + half;
  assign rem_sh  = {rem_q, 1'b0};
  assign div_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign sum     = $signed({2'b00, v1_q, {QW{1'b0}}}) + prod_q;

  // Table writes
  assign wr_en   = in_acc && (action_i == cil_pkg::ACT_WRITE) &&
                   ({{(32-cil_pkg::INDEX_W){1'b0}}, point_index_i} < 32'(MAX_POINTS));
  assign wr_addr = AW'(point_index_i);
  assign wr_data = '{tenor: tenor_i, value: point_value_i};

  // Sequencer: next state, memory reads and datapath
  always_comb begin
    state_d     = state_q;
    count_d     = cfg_we_i ? cfg_wdata_i : count_q;
    tq_d        = tq_q;
    n_d         = n_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    t2_d        = t2_q;
    v1_d        = v1_q;
    diff_d      = diff_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quot_d      = quot_q;
    step_d      = step_q;
    prod_d      = prod_q;
    res_value_d = res_value_q;
    res_err_d   = res_err_q;
    rd_en       = 1'b0;
    rd_addr     = AW'(probe);

    unique case (state_q)
      cil_pkg::ST_IDLE: begin
        if (in_acc && (action_i == cil_pkg::ACT_QUERY)) begin
          tq_d    = tenor_i;
          n_d     = n_cap;
          first_d = '0;
          cnt_d   = n_cap;
          if (n_cap == '0) begin
            res_value_d = '0;
            res_err_d   = 1'b1;
            state_d     = cil_pkg::ST_OUT;
          end else begin
            res_err_d = 1'b0;
            state_d   = cil_pkg::ST_SRD;
          end
        end
      end
      cil_pkg::ST_SRD: begin
        if (cnt_q == '0) begin
          state_d = cil_pkg::ST_POS;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(probe);
          state_d = cil_pkg::ST_SCMP;
        end
      end
      cil_pkg::ST_SCMP: begin
        if (rd_data.tenor < tq_q) begin
          first_d = probe + CW'(1);
          cnt_d   = cnt_q - half - CW'(1);
        end else begin
          cnt_d = half;
        end
        state_d = cil_pkg::ST_SRD;
      end
      cil_pkg::ST_POS: begin
        rd_en = 1'b1;
        priority if (first_q == '0) begin
          rd_addr = '0;
          state_d = cil_pkg::ST_EDGE;
        end else if (first_q >= n_q) begin
          rd_addr = AW'(n_q - CW'(1));
          state_d = cil_pkg::ST_EDGE;
        end else begin
          rd_addr = AW'(first_q);
          state_d = cil_pkg::ST_HI;
        end
      end
      cil_pkg::ST_EDGE: begin
        res_value_d = rd_data.value;
        state_d     = cil_pkg::ST_OUT;
      end
      cil_pkg::ST_HI: begin
        t2_d   = rd_data.tenor;
        diff_d = {1'b0, rd_data.value};
        if (rd_data.tenor == tq_q) begin
          res_value_d = rd_data.value;
          state_d     = cil_pkg::ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(first_q - CW'(1));
          state_d = cil_pkg::ST_LO;
        end
      end
      cil_pkg::ST_LO: begin
        // t1 < t < t2, so the remainder starts below the divisor
        v1_d    = rd_data.value;
        diff_d  = diff_q - {1'b0, rd_data.value};
        rem_d   = tq_q - rd_data.tenor;
        dvs_d   = t2_q - rd_data.tenor;
        quot_d  = '0;
        step_d  = '0;
        state_d = cil_pkg::ST_DIV;
      end
      cil_pkg::ST_DIV: begin
        // restoring division, one weight bit a cycle
        rem_d  = div_ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
        quot_d = {quot_q[QW-2:0], div_ge};
        step_d = step_q + cil_pkg::STEP_W'(1);
        if (step_q == cil_pkg::STEP_W'(QW - 1)) begin
          state_d = cil_pkg::ST_MUL;
        end
      end
      cil_pkg::ST_MUL: begin
        // signed difference times unsigned weight, both taken to product width
        prod_d  = $signed({{(PW-VW-1){diff_q[VW]}}, diff_q}) *
                  $signed({{(PW-QW){1'b0}}, quot_q});
        state_d = cil_pkg::ST_SUM;
      end
      cil_pkg::ST_SUM: begin
        res_value_d = sum[QW+VW-1:QW];
        state_d     = cil_pkg::ST_OUT;
      end
      cil_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = cil_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cil_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_value_d = out_value_q;
    out_err_d   = out_err_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_value_d = res_value_q;
      out_err_d   = res_err_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cil_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tq_q        <= tq_d;
    n_q         <= n_d;
    first_q     <= first_d;
    cnt_q       <= cnt_d;
    t2_q        <= t2_d;
    v1_q        <= v1_d;
    diff_q      <= diff_d;
    rem_q       <= rem_d;
    dvs_q       <= dvs_d;
    quot_q      <= quot_d;
    step_q      <= step_d;
    prod_q      <= prod_d;
    res_value_q <= res_value_d;
    res_err_q   <= res_err_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign curve_value_o = out_value_q;
  assign empty_error_o = out_err_q;

  // An empty-table answer always carries a zero value
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_error_o |-> curve_value_o == '0)
    else $error("empty-table result with non-zero value");

  // Search probes stay inside the valid points
  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cil_pkg::ST_SRD) && (cnt_q != '0) |-> probe < n_q)
    else $error("search probe beyond point count");

  // Weight division keeps its remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cil_pkg::ST_DIV |-> rem_q < dvs_q)
    else $error("division remainder not below divisor");

  // A write transaction never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == cil_pkg::ACT_WRITE) && !out_valid_o |=> !out_valid_o)
    else $error("result after a write transaction");

endmodule
